### rtl/core/tfc_pkg.sv
`default_nettype none
package tfc_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned PalIdxW      = $clog2(PaletteDepth);
  localparam int unsigned WidthW       = 11;
  localparam int unsigned ColW         = 10;
  localparam int unsigned AddrW        = 20;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 11;

  localparam logic [WidthW-1:0] PitchMax    = 11'd1024;
  localparam logic [WidthW-1:0] WidthReset  = 11'd64;
  localparam logic [7:0]        KeyNearMax  = 8'hfe;
  localparam logic [7:0]        KeyMax      = 8'hff;
  localparam logic [7:0]        AlphaOpaque = 8'hff;

  typedef enum logic [1:0] {
    FMT_PAL8   = 2'd0,
    FMT_BGR24  = 2'd1,
    FMT_BGRA32 = 2'd2
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_FORMAT = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PAL_WRITE = 1'b0,
    FUNC_PIXEL     = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [7:0] color_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      texel;
    logic [AddrW-1:0] texel_address;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [PalIdxW-1:0] addr;
    logic [23:0]        wdata;
  } pal_req_t;

endpackage
`default_nettype wire

### rtl/core/tfc_palette_ram.sv
`default_nettype none
module tfc_palette_ram (
  input  wire logic              clk_i,
  input  wire tfc_pkg::pal_req_t req_i,
  output logic [23:0]            rdata_o
);
  import tfc_pkg::*;

  logic [23:0] mem [PaletteDepth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/texel_format_converter_unit.sv
// Texel format converter.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries palette writes
// and source pixels; a transaction is taken on an edge with valid high and
// stall low. A palette write stores one BGR entry and gives no result. Each
// pixel gives one texel and its texture address on the output channel
// (out_valid_o / out_stall_i / out_item_o).
// A pixel passes through the palette read stage, then the output register,
// before it appears on the output. Throughput is one transaction per cycle
// while in_stall_o is low; the single-port palette is read or written once
// per accept. A palette write is visible to a pixel accepted in the next cycle.
// Configuration: cfg_we_i writes register cfg_idx_i (0 = source format,
// 1 = image width); writing either restarts the image at row 0, column 0.
// Write configuration only while the block is idle.
// Reset: format 8-bit palette, width 64, counters zero, pipeline empty.
// The palette holds no defined data until written.
// When the receiver stalls, the output holds; one more pixel can wait in the
// palette read stage, after which in_stall_o rises.
`default_nettype none
module texel_format_converter_unit #(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tfc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tfc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire tfc_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output tfc_pkg::out_item_t                  out_item_o
);
  import tfc_pkg::*;

  localparam int unsigned RowW = $clog2(MAX_SIZE);
  localparam int unsigned SumW = (RowW + ColW + 1 > AddrW) ? RowW + ColW + 1 : AddrW;
  localparam logic [RowW-1:0] RowLast = RowW'(MAX_SIZE - 1);

  logic [1:0]        fmt_q;
  logic [WidthW-1:0] width_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;

  logic              s1_valid_q;
  logic [1:0]        s1_fmt_q;
  logic [7:0]        s1_b_q, s1_g_q, s1_r_q, s1_a_q;
  logic [AddrW-1:0]  s1_addr_q;

  logic              out_valid_q;
  out_item_t         out_q, out_d;

  logic              adv, in_acc, pix_acc;
  logic [WidthW-1:0] w_clamp, w_eff;
  logic [3:0]        pshift;
  logic [SumW-1:0]   addr_sum;
  logic [WidthW-1:0] col_inc;
  logic [23:0]       pal_rdata;
  pal_req_t          pal_req;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_item_i.func == FUNC_PIXEL);

  always_comb begin
    w_clamp = width_q;
    if (w_clamp == '0) begin
      w_clamp = WidthW'(1);
    end
    if (w_clamp > PitchMax) begin
      w_clamp = PitchMax;
    end
    w_eff = w_clamp;
    if (fmt_q == FMT_PAL8 || fmt_q == FMT_BGR24) begin
      w_eff = w_clamp + WidthW'(w_clamp[0]);
    end
    if (w_eff <= 11'd64) begin
      pshift = 4'd6;
    end else if (w_eff <= 11'd128) begin
      pshift = 4'd7;
    end else if (w_eff <= 11'd256) begin
      pshift = 4'd8;
    end else if (w_eff <= 11'd512) begin
      pshift = 4'd9;
    end else begin
      pshift = 4'd10;
    end
  end

  assign addr_sum = (SumW'(row_q) << pshift) + SumW'(col_q);
  assign col_inc  = WidthW'(col_q) + WidthW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_q >= RowLast) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_PAL8;
      width_q <= WidthReset;
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_FORMAT: begin
          fmt_q <= cfg_data_i[1:0];
          col_q <= '0;
          row_q <= '0;
        end
        CFG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[WidthW-1:0];
          col_q   <= '0;
          row_q   <= '0;
        end
        default: begin
          col_q <= col_d;
          row_q <= row_d;
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    pal_req.we    = in_acc && (in_item_i.func == FUNC_PAL_WRITE);
    pal_req.re    = pix_acc;
    pal_req.addr  = in_item_i.color_index[PalIdxW-1:0];
    pal_req.wdata = {in_item_i.blue, in_item_i.green, in_item_i.red};
  end

  tfc_palette_ram u_palette (
    .clk_i   (clk_i),
    .req_i   (pal_req),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (!in_stall_o) begin
        s1_valid_q <= pix_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_fmt_q  <= fmt_q;
      s1_b_q    <= in_item_i.blue;
      s1_g_q    <= in_item_i.green;
      s1_r_q    <= in_item_i.red;
      s1_a_q    <= in_item_i.alpha;
      s1_addr_q <= addr_sum[AddrW-1:0];
    end
    if (adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d.texel_address = s1_addr_q;
    case (s1_fmt_q)
      FMT_PAL8: begin
        if (pal_rdata[7:0] >= KeyNearMax && pal_rdata[23:16] >= KeyNearMax &&
            pal_rdata[15:8] == '0) begin
          out_d.texel = '0;
        end else begin
          out_d.texel = {AlphaOpaque, pal_rdata};
        end
      end
      FMT_BGR24: begin
        if (s1_r_q == KeyMax && s1_b_q == KeyMax) begin
          out_d.texel = '0;
        end else begin
          out_d.texel = {AlphaOpaque, s1_b_q, s1_g_q, s1_r_q};
        end
      end
      default: begin
        out_d.texel = {s1_a_q, s1_b_q, s1_g_q, s1_r_q};
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with no pending pixel");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WidthW'(col_q) < w_eff)
    else $error("column counter beyond effective width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RowLast)
    else $error("row counter beyond MAX_SIZE");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pixel lost between read stage and output");

endmodule
`default_nettype wire
